// ===== rtl/swnla_pkg.sv =====
package swnla_pkg;

    localparam logic [3:0] OP_ADDL   = 4'd0;
    localparam logic [3:0] OP_ADDW   = 4'd1;
    localparam logic [3:0] OP_SUBL   = 4'd2;
    localparam logic [3:0] OP_SUBW   = 4'd3;
    localparam logic [3:0] OP_ADDHN  = 4'd4;
    localparam logic [3:0] OP_SUBHN  = 4'd5;
    localparam logic [3:0] OP_RADDHN = 4'd6;
    localparam logic [3:0] OP_RSUBHN = 4'd7;
    localparam logic [3:0] OP_SHLL   = 4'd8;
    localparam logic [3:0] OP_XTN    = 4'd9;
    localparam logic [3:0] OP_SQXTN  = 4'd10;
    localparam logic [3:0] OP_UQXTN  = 4'd11;
    localparam logic [3:0] OP_SQXTUN = 4'd12;

    localparam logic [1:0] LSZ_8  = 2'd0;
    localparam logic [1:0] LSZ_16 = 2'd1;
    localparam logic [1:0] LSZ_32 = 2'd2;
    localparam logic [1:0] LSZ_RSV = 2'd3;

    localparam logic [1:0] NK_XTN = 2'd0;
    localparam logic [1:0] NK_SQ  = 2'd1;
    localparam logic [1:0] NK_UQ  = 2'd2;
    localparam logic [1:0] NK_SQU = 2'd3;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);

    typedef struct packed {
        logic       widen;
        logic       narrow;
        logic       wide_src;
        logic       is_sub;
        logic       is_shll;
        logic       hn;
        logic       rnd;
        logic [1:0] nkind;
        logic       scal;
    } t_cls;

    typedef struct packed {
        t_cls         cls;
        logic [1:0]   lsz;
        logic         sgn;
        logic         up;
        logic [4:0]   sh;
        logic [127:0] a;
        logic [127:0] b;
        logic [63:0]  old;
    } t_item;

endpackage

// ===== rtl/swnla_front.sv =====
module swnla_front (
    input  logic [3:0]       i_op,
    input  logic [1:0]       i_lane_size,
    input  logic             i_sign_extend,
    input  logic             i_upper_half,
    input  logic             i_scalar_form,
    input  logic [4:0]       i_shift_amount,
    input  logic [63:0]      i_a_low,
    input  logic [63:0]      i_a_high,
    input  logic [63:0]      i_b_low,
    input  logic [63:0]      i_b_high,
    input  logic [63:0]      i_old_dest_low,
    output swnla_pkg::t_item o_item
);

    swnla_pkg::t_cls cls;

    always_comb begin
        cls = '0;
        unique case (i_op)
            swnla_pkg::OP_ADDL: begin
                cls.widen = 1'b1;
            end
            swnla_pkg::OP_ADDW: begin
                cls.widen    = 1'b1;
                cls.wide_src = 1'b1;
            end
            swnla_pkg::OP_SUBL: begin
                cls.widen  = 1'b1;
                cls.is_sub = 1'b1;
            end
            swnla_pkg::OP_SUBW: begin
                cls.widen    = 1'b1;
                cls.wide_src = 1'b1;
                cls.is_sub   = 1'b1;
            end
            swnla_pkg::OP_ADDHN: begin
                cls.narrow = 1'b1;
                cls.hn     = 1'b1;
            end
            swnla_pkg::OP_SUBHN: begin
                cls.narrow = 1'b1;
                cls.hn     = 1'b1;
                cls.is_sub = 1'b1;
            end
            swnla_pkg::OP_RADDHN: begin
                cls.narrow = 1'b1;
                cls.hn     = 1'b1;
                cls.rnd    = 1'b1;
            end
            swnla_pkg::OP_RSUBHN: begin
                cls.narrow = 1'b1;
                cls.hn     = 1'b1;
                cls.rnd    = 1'b1;
                cls.is_sub = 1'b1;
            end
            swnla_pkg::OP_SHLL: begin
                cls.widen   = 1'b1;
                cls.is_shll = 1'b1;
            end
            swnla_pkg::OP_XTN: begin
                cls.narrow = 1'b1;
                cls.nkind  = swnla_pkg::NK_XTN;
            end
            swnla_pkg::OP_SQXTN: begin
                cls.narrow = 1'b1;
                cls.nkind  = swnla_pkg::NK_SQ;
                cls.scal   = i_scalar_form;
            end
            swnla_pkg::OP_UQXTN: begin
                cls.narrow = 1'b1;
                cls.nkind  = swnla_pkg::NK_UQ;
                cls.scal   = i_scalar_form;
            end
            swnla_pkg::OP_SQXTUN: begin
                cls.narrow = 1'b1;
                cls.nkind  = swnla_pkg::NK_SQU;
                cls.scal   = i_scalar_form;
            end
            default: begin
                cls = '0;
            end
        endcase
    end

    always_comb begin
        o_item.cls = cls;
        o_item.lsz = (i_lane_size == swnla_pkg::LSZ_RSV) ? swnla_pkg::LSZ_32 : i_lane_size;
        o_item.sgn = i_sign_extend;
        o_item.up  = i_upper_half;
        o_item.sh  = i_shift_amount;
        o_item.a   = {i_a_high, i_a_low};
        o_item.b   = {i_b_high, i_b_low};
        o_item.old = i_old_dest_low;
    end

endmodule

// ===== rtl/swnla_queue.sv =====
module swnla_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  swnla_pkg::t_item i_item,
    output logic             o_full,
    output logic             o_valid,
    output swnla_pkg::t_item o_item,
    input  logic             i_pop
);

    swnla_pkg::t_item                r_mem [swnla_pkg::QDepth];
    logic [swnla_pkg::QPtrW-1:0]     r_wr_ptr;
    logic [swnla_pkg::QPtrW-1:0]     r_rd_ptr;
    logic [swnla_pkg::QPtrW:0]       r_count;
    logic [swnla_pkg::QPtrW-1:0]     n_wr_ptr;
    logic [swnla_pkg::QPtrW-1:0]     n_rd_ptr;
    logic [swnla_pkg::QPtrW:0]       n_count;
    logic                            push;
    logic                            pop;

    assign o_full  = (r_count == (swnla_pkg::QPtrW+1)'(swnla_pkg::QDepth));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/swnla_back.sv =====
module swnla_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  swnla_pkg::t_item i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [63:0]      o_result_low,
    output logic [63:0]      o_result_high
);

    logic [127:0] wres [3];
    logic [63:0]  nres [3];
    logic [127:0] wsel;
    logic [63:0]  nsel;
    logic         r_valid;
    logic         n_valid;
    logic [63:0]  r_res_low;
    logic [63:0]  r_res_high;
    logic [63:0]  n_res_low;
    logic [63:0]  n_res_high;

    for (genvar sz = 0; sz < 3; sz++) begin : g_size
        localparam int N = 8 << sz;
        localparam int W = 2 * N;
        localparam int L = 64 / N;

        logic [63:0]  src_a;
        logic [63:0]  src_b;
        logic [N-1:0] na;
        logic [N-1:0] nb;
        logic [W-1:0] ea;
        logic [W-1:0] eb;
        logic [W-1:0] xa;
        logic [W-1:0] wa;
        logic [W-1:0] wbv;
        logic [W-1:0] s;
        logic [N-1:0] nv;
        logic [N-1:0] lo;

        always_comb begin
            wres[sz] = '0;
            nres[sz] = '0;
            src_a    = i_item.up ? i_item.a[127:64] : i_item.a[63:0];
            src_b    = i_item.up ? i_item.b[127:64] : i_item.b[63:0];
            for (int i = 0; i < L; i++) begin
                na = src_a[i*N +: N];
                nb = src_b[i*N +: N];
                ea = i_item.sgn ? {{N{na[N-1]}}, na} : {{N{1'b0}}, na};
                eb = i_item.sgn ? {{N{nb[N-1]}}, nb} : {{N{1'b0}}, nb};
                xa = i_item.cls.wide_src ? i_item.a[i*W +: W] : ea;
                if (i_item.cls.is_shll) begin
                    wres[sz][i*W +: W] = ea << i_item.sh;
                end else if (i_item.cls.is_sub) begin
                    wres[sz][i*W +: W] = xa - eb;
                end else begin
                    wres[sz][i*W +: W] = xa + eb;
                end

                wa  = i_item.a[i*W +: W];
                wbv = i_item.b[i*W +: W];
                lo  = wa[N-1:0];
                s   = i_item.cls.is_sub ? wa - wbv : wa + wbv;
                if (i_item.cls.rnd) begin
                    s = s + (W'(1) << (N - 1));
                end
                if (i_item.cls.hn) begin
                    nv = s[W-1:N];
                end else begin
                    case (i_item.cls.nkind)
                        swnla_pkg::NK_SQ: begin
                            if ((&wa[W-1:N-1]) || !(|wa[W-1:N-1])) begin
                                nv = lo;
                            end else if (wa[W-1]) begin
                                nv = {1'b1, {(N-1){1'b0}}};
                            end else begin
                                nv = {1'b0, {(N-1){1'b1}}};
                            end
                        end
                        swnla_pkg::NK_UQ: begin
                            nv = (|wa[W-1:N]) ? '1 : lo;
                        end
                        swnla_pkg::NK_SQU: begin
                            if (wa[W-1]) begin
                                nv = '0;
                            end else begin
                                nv = (|wa[W-1:N]) ? '1 : lo;
                            end
                        end
                        default: begin
                            nv = lo;
                        end
                    endcase
                end
                if (!i_item.cls.scal || i == 0) begin
                    nres[sz][i*N +: N] = nv;
                end
            end
        end
    end

    always_comb begin
        unique case (i_item.lsz)
            swnla_pkg::LSZ_8: begin
                wsel = wres[0];
                nsel = nres[0];
            end
            swnla_pkg::LSZ_16: begin
                wsel = wres[1];
                nsel = nres[1];
            end
            default: begin
                wsel = wres[2];
                nsel = nres[2];
            end
        endcase
    end

    always_comb begin
        n_res_low  = '0;
        n_res_high = '0;
        if (i_item.cls.widen) begin
            n_res_low  = wsel[63:0];
            n_res_high = wsel[127:64];
        end else if (i_item.cls.narrow) begin
            if (i_item.cls.scal || !i_item.up) begin
                n_res_low = nsel;
            end else begin
                n_res_low  = i_item.old;
                n_res_high = nsel;
            end
        end
    end

    assign o_pop   = i_q_valid && (!r_valid || !i_stall);
    assign n_valid = o_pop || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res_low  <= n_res_low;
            r_res_high <= n_res_high;
        end
    end

    assign o_valid       = r_valid;
    assign o_result_low  = r_res_low;
    assign o_result_high = r_res_high;

endmodule

// ===== rtl/simd_widen_narrow_lane_alu.sv =====
// channel   valid     stall     payload
// input     i_valid   o_stall   i_op .. i_old_dest_low
// output    o_valid   i_stall   o_result_low, o_result_high
//
// One transaction per cycle sustained while i_stall is low. Decode and queue
// write happen at the accepting edge; execute writes the output register, and
// the result turns valid, at a later edge once that register is empty or not stalled.
// A four-entry queue between decode and execute absorbs output stalls;
// o_stall rises only when that queue is full.
// Reset empties the queue and drops any pending result.
module simd_widen_narrow_lane_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_op,
    input  logic [1:0]  i_lane_size,
    input  logic        i_sign_extend,
    input  logic        i_upper_half,
    input  logic        i_scalar_form,
    input  logic [4:0]  i_shift_amount,
    input  logic [63:0] i_a_low,
    input  logic [63:0] i_a_high,
    input  logic [63:0] i_b_low,
    input  logic [63:0] i_b_high,
    input  logic [63:0] i_old_dest_low,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_low,
    output logic [63:0] o_result_high
);

    swnla_pkg::t_item dec_item;
    swnla_pkg::t_item q_item;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;

    swnla_front u_front (
        .i_op           (i_op),
        .i_lane_size    (i_lane_size),
        .i_sign_extend  (i_sign_extend),
        .i_upper_half   (i_upper_half),
        .i_scalar_form  (i_scalar_form),
        .i_shift_amount (i_shift_amount),
        .i_a_low        (i_a_low),
        .i_a_high       (i_a_high),
        .i_b_low        (i_b_low),
        .i_b_high       (i_b_high),
        .i_old_dest_low (i_old_dest_low),
        .o_item         (dec_item)
    );

    swnla_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_item  (dec_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    swnla_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_item        (q_item),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_low  (o_result_low),
        .o_result_high (o_result_high)
    );

    assign o_stall = q_full;

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> q_valid)
        else $error("queue full while empty");

    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> o_valid)
        else $error("issued transaction lost");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !q_valid)
        else $error("state survives reset");

endmodule
